>>> design/clg_pkg.sv
`default_nettype none

package clg_pkg;

	localparam int SENSOR_COUNT = 12;
	localparam int IDX_W        = $clog2(SENSOR_COUNT);
	localparam int LAST_IDX     = SENSOR_COUNT - 1;

	localparam int FRAC_BITS = 8;
	localparam int RAW_W     = 16;
	localparam int SCALE_W   = 15;
	localparam int THRESH_W  = 16;
	localparam int HEIGHT_W  = 16;
	localparam int FULL_W    = 12;
	localparam int TALLY_W   = 5;
	localparam int LEVEL_W   = 20;
	localparam int PCT_W     = 15;
	localparam int PCT_NUM_W = 27;
	localparam int DIV_CNT_W = $clog2(PCT_NUM_W);

	localparam logic [TALLY_W-1:0] TALLY_MAX = '1;
	localparam int                 PCT_SCALE = 100;

	localparam logic [SCALE_W-1:0] SCALE_FIRST_RST = 15'h01D0;
	localparam logic [SCALE_W-1:0] SCALE_MID_RST   = 15'h0100;
	localparam logic [SCALE_W-1:0] SCALE_LAST_RST  = 15'h01C0;

	localparam logic [THRESH_W-1:0] THRESH_RST = 16'd512;
	localparam logic [HEIGHT_W-1:0] HEIGHT_RST = 16'd2560;
	localparam logic [FULL_W-1:0]   FULL_RST   = 12'd100;

	typedef enum logic [0:0] {
		ACT_CAL    = 1'b0,
		ACT_SAMPLE = 1'b1
	} clg_action_t;

	typedef enum logic [1:0] {
		REG_THRESHOLD     = 2'd0,
		REG_SENSOR_HEIGHT = 2'd1,
		REG_FULL_LEVEL    = 2'd2
	} clg_reg_t;

	// one calibration entry
	typedef struct packed {
		logic signed [15:0]   offset;
		logic [SCALE_W-1:0]   scale;
	} clg_cal_t;

	// request to the calibration memory
	typedef struct packed {
		logic             wr_en;
		logic             rd_en;
		logic [IDX_W-1:0] addr;
		clg_cal_t         wdata;
	} clg_ram_req_t;

	// entry value of a sensor that was never calibrated
	function automatic clg_cal_t cal_default(input logic [IDX_W-1:0] idx);
		clg_cal_t e;
		e.offset = '0;
		if (idx == IDX_W'(0))
			e.scale = SCALE_FIRST_RST;
		else if (idx == IDX_W'(LAST_IDX))
			e.scale = SCALE_LAST_RST;
		else
			e.scale = SCALE_MID_RST;
		return e;
	endfunction

endpackage

`default_nettype wire

>>> design/capacitive_liquid_level_gauge.sv
`default_nettype none

// Capacitive liquid level gauge.
// Input channel (in_valid / in_stall): one item per electrode. action 0 stores
// empty_offset and scale_factor for sensor_index; action 1 gives a raw_count.
// A scan runs index 0 first; index 0 restarts the submerged tally. An index of
// 12 or more is dropped. Only a sample on the last index gives a result item.
// Output channel (out_valid / out_stall): level_mm (12.8), level_percent (7.8)
// and weighted_count. Config channel (cfg_valid / cfg_ready, always ready):
// cfg_index 0 threshold, 1 sensor height, 2 full level; other indexes ignored.
// Flow: a calibrate item does not stall the input; a sample stalls it while it
// is read, multiplied and compared. A last-index sample then passes level, clamp
// and the 27-step serial divider for the percentage before its result is pushed;
// the next item can be taken while that result waits in the output register.
// Reset: calibration reads as defaults (offset 0, gains 0x1D0 / 0x100 /
// 0x1C0) through per-entry valid bits, tally 0, registers to defaults.
// Receiver stall: the result register holds; the core waits only if a second
// result is ready before the first is taken.

module capacitive_liquid_level_gauge (
	input  wire logic                          clk,
	input  wire logic                          arst_n,
	input  wire logic                          in_valid,
	output logic                               in_stall,
	input  wire logic                          action,
	input  wire logic [3:0]                    sensor_index,
	input  wire logic [clg_pkg::RAW_W-1:0]     raw_count,
	input  wire logic signed [15:0]            empty_offset,
	input  wire logic [clg_pkg::SCALE_W-1:0]   scale_factor,
	output logic                               out_valid,
	input  wire logic                          out_stall,
	output logic [clg_pkg::LEVEL_W-1:0]        level_mm,
	output logic [clg_pkg::PCT_W-1:0]          level_percent,
	output logic [clg_pkg::TALLY_W-1:0]        weighted_count,
	input  wire logic                          cfg_valid,
	output logic                               cfg_ready,
	input  wire logic [1:0]                    cfg_index,
	input  wire logic [15:0]                   cfg_data
);

	typedef enum logic [7:0] {
		S_IDLE = 8'b0000_0001,
		S_RD   = 8'b0000_0010,
		S_CMP  = 8'b0000_0100,
		S_LVL  = 8'b0000_1000,
		S_CLP  = 8'b0001_0000,
		S_PCT  = 8'b0010_0000,
		S_DIV  = 8'b0100_0000,
		S_PUSH = 8'b1000_0000
	} state_t;

	state_t state_q, state_d;

	// config registers
	logic [clg_pkg::THRESH_W-1:0] thresh_q;
	logic [clg_pkg::HEIGHT_W-1:0] height_q;
	logic [clg_pkg::FULL_W-1:0]   full_q;

	logic [clg_pkg::TALLY_W-1:0]  tally_q;

	// pipeline registers of one sample
	logic [clg_pkg::RAW_W-1:0]    raw_s1;
	logic [clg_pkg::IDX_W-1:0]    idx_s1;
	logic signed [33:0]           prod_s2;
	logic [clg_pkg::LEVEL_W-1:0]  lvl_s3;
	logic [clg_pkg::LEVEL_W-1:0]  lvl_s4;

	// output register
	logic                         out_valid_q;
	logic [clg_pkg::LEVEL_W-1:0]  level_q;
	logic [clg_pkg::PCT_W-1:0]    pct_q;
	logic [clg_pkg::TALLY_W-1:0]  wcount_q;

	logic                         in_acc;
	logic                         idx_ok;
	logic [clg_pkg::IDX_W-1:0]    idx_in;
	clg_pkg::clg_ram_req_t        ram_req;
	clg_pkg::clg_cal_t            cal;

	logic signed [17:0]           diff;
	logic [24:0]                  thr_lim;
	logic                         submerged;
	logic                         first_idx;
	logic                         last_idx;
	logic [clg_pkg::TALLY_W:0]    tally_sum;
	logic [clg_pkg::TALLY_W-1:0]  tally_new;

	logic [clg_pkg::LEVEL_W-1:0]  full_fx;
	logic signed [21:0]           limit;
	logic                         over;

	logic                         div_start;
	logic                         div_done;
	logic [clg_pkg::PCT_NUM_W-1:0] pct_num;
	logic [clg_pkg::PCT_NUM_W-1:0] quotient;
	logic                         slot_free;

	// --- input side ---
	assign in_stall = (state_q != S_IDLE);
	assign in_acc   = in_valid && !in_stall;
	assign idx_in   = clg_pkg::IDX_W'(sensor_index);
	assign idx_ok   = (sensor_index < 4'(clg_pkg::SENSOR_COUNT));

	always_comb begin
		ram_req              = '0;
		ram_req.addr         = idx_in;
		ram_req.wdata.offset = empty_offset;
		ram_req.wdata.scale  = scale_factor;
		if (in_acc && idx_ok) begin
			ram_req.wr_en = (clg_pkg::clg_action_t'(action) == clg_pkg::ACT_CAL);
			ram_req.rd_en = (clg_pkg::clg_action_t'(action) == clg_pkg::ACT_SAMPLE);
		end
	end

	clg_cal_ram u_ram (
		.clk    (clk),
		.arst_n (arst_n),
		.req    (ram_req),
		.rdata  (cal)
	);

	// --- sample path ---
	// raw minus offset, exact in 18 bits signed
	assign diff = $signed({2'b00, raw_s1}) - $signed({{2{cal.offset[15]}}, cal.offset});

	// floor(p / 256) > T  is  p >= (T + 1) * 256
	assign thr_lim   = {(17'(thresh_q) + 17'd1), 8'b0};
	assign submerged = (prod_s2 >= $signed({9'b0, thr_lim}));

	assign first_idx = (idx_s1 == clg_pkg::IDX_W'(0));
	assign last_idx  = (idx_s1 == clg_pkg::IDX_W'(clg_pkg::LAST_IDX));

	always_comb begin
		tally_sum = {1'b0, first_idx ? {clg_pkg::TALLY_W{1'b0}} : tally_q};
		if (submerged)
			tally_sum = tally_sum + ((first_idx || last_idx) ? 6'd1 : 6'd2);
		tally_new = (tally_sum > {1'b0, clg_pkg::TALLY_MAX}) ?
			clg_pkg::TALLY_MAX : tally_sum[clg_pkg::TALLY_W-1:0];
	end

	// --- level and clamp ---
	assign full_fx = {full_q, 8'b0};
	assign limit   = $signed({2'b0, full_fx}) - $signed({8'b0, height_q[15:2]});
	assign over    = $signed({2'b0, lvl_s3}) > limit;

	assign pct_num   = clg_pkg::PCT_NUM_W'(lvl_s4) * clg_pkg::PCT_NUM_W'(clg_pkg::PCT_SCALE);
	assign div_start = (state_q == S_PCT);

	clg_div u_div (
		.clk      (clk),
		.arst_n   (arst_n),
		.start    (div_start),
		.dividend (pct_num),
		.divisor  (full_q),
		.done     (div_done),
		.quotient (quotient)
	);

	assign slot_free = !out_valid_q || !out_stall;

	// --- sequencer ---
	always_comb begin
		state_d = state_q;
		unique case (state_q)
			S_IDLE: begin
				if (in_acc && idx_ok &&
				    clg_pkg::clg_action_t'(action) == clg_pkg::ACT_SAMPLE)
					state_d = S_RD;
			end
			S_RD:   state_d = S_CMP;
			S_CMP:  state_d = last_idx ? S_LVL : S_IDLE;
			S_LVL:  state_d = S_CLP;
			S_CLP:  state_d = S_PCT;
			S_PCT:  state_d = S_DIV;
			S_DIV:  state_d = div_done ? S_PUSH : S_DIV;
			S_PUSH: state_d = slot_free ? S_IDLE : S_PUSH;
			default: state_d = S_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_IDLE;
			tally_q     <= '0;
			thresh_q    <= clg_pkg::THRESH_RST;
			height_q    <= clg_pkg::HEIGHT_RST;
			full_q      <= clg_pkg::FULL_RST;
			out_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			if (state_q == S_CMP)
				tally_q <= tally_new;
			if (cfg_valid && cfg_ready) begin
				case (clg_pkg::clg_reg_t'(cfg_index))
					clg_pkg::REG_THRESHOLD:     thresh_q <= cfg_data;
					clg_pkg::REG_SENSOR_HEIGHT: height_q <= cfg_data;
					clg_pkg::REG_FULL_LEVEL:    full_q   <= cfg_data[clg_pkg::FULL_W-1:0];
					default: ;
				endcase
			end
			if (state_q == S_PUSH && slot_free)
				out_valid_q <= 1'b1;
			else if (!out_stall)
				out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (in_acc) begin
			raw_s1 <= raw_count;
			idx_s1 <= idx_in;
		end
		if (state_q == S_RD)
			prod_s2 <= diff * $signed({1'b0, cal.scale});
		if (state_q == S_LVL)
			lvl_s3 <= clg_pkg::LEVEL_W'(tally_q * height_q[15:1]);
		if (state_q == S_CLP) begin
			if (full_q == '0)
				lvl_s4 <= '0;
			else if (over)
				lvl_s4 <= full_fx;
			else
				lvl_s4 <= lvl_s3;
		end
		if (state_q == S_PUSH && slot_free) begin
			level_q  <= lvl_s4;
			pct_q    <= (full_q == '0) ? '0 : quotient[clg_pkg::PCT_W-1:0];
			wcount_q <= tally_q;
		end
	end

	assign cfg_ready      = 1'b1;
	assign out_valid      = out_valid_q;
	assign level_mm       = level_q;
	assign level_percent  = pct_q;
	assign weighted_count = wcount_q;

	a_result_from_push: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(out_valid_q) |-> $past(state_q == S_PUSH))
		else $error("result raised outside the push step");

	a_div_done_in_wait: assert property (@(posedge clk) disable iff (!arst_n)
		div_done |-> (state_q == S_DIV))
		else $error("divider finished while not awaited");

	a_level_clamped: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == S_PCT) |-> (lvl_s4 <= full_fx))
		else $error("clamped level above full height");

	a_no_overwrite: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid_q && out_stall) |=> (out_valid_q && $stable(level_q)))
		else $error("waiting result overwritten");

endmodule

`default_nettype wire

>>> design/clg_cal_ram.sv
`default_nettype none

module clg_cal_ram (
	input  wire logic                  clk,
	input  wire logic                  arst_n,
	input  wire clg_pkg::clg_ram_req_t req,
	output clg_pkg::clg_cal_t          rdata
);

	clg_pkg::clg_cal_t                  mem [clg_pkg::SENSOR_COUNT];
	clg_pkg::clg_cal_t                  rd_q;
	logic [clg_pkg::SENSOR_COUNT-1:0]   valid_q;
	logic                               rd_valid_q;
	logic [clg_pkg::IDX_W-1:0]          rd_addr_q;

	always_ff @(posedge clk) begin
		if (req.wr_en)
			mem[req.addr] <= req.wdata;
		if (req.rd_en)
			rd_q <= mem[req.addr];
	end

	// valid bits stand in for the reset contents
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q    <= '0;
			rd_valid_q <= 1'b0;
			rd_addr_q  <= '0;
		end else begin
			if (req.wr_en)
				valid_q[req.addr] <= 1'b1;
			if (req.rd_en) begin
				rd_valid_q <= valid_q[req.addr];
				rd_addr_q  <= req.addr;
			end
		end
	end

	assign rdata = rd_valid_q ? rd_q : clg_pkg::cal_default(rd_addr_q);

	a_one_port: assert property (@(posedge clk) disable iff (!arst_n)
		req.wr_en |-> !req.rd_en)
		else $error("calibration memory: read and write in one cycle");

	a_valid_sticky: assert property (@(posedge clk) disable iff (!arst_n)
		req.wr_en |=> valid_q[$past(req.addr)])
		else $error("calibration memory: written entry not marked valid");

	a_range: assert property (@(posedge clk) disable iff (!arst_n)
		(req.wr_en || req.rd_en) |-> (req.addr < clg_pkg::IDX_W'(clg_pkg::SENSOR_COUNT)))
		else $error("calibration memory: address out of range");

endmodule

`default_nettype wire

>>> design/clg_div.sv
`default_nettype none

module clg_div (
	input  wire logic                           clk,
	input  wire logic                           arst_n,
	input  wire logic                           start,
	input  wire logic [clg_pkg::PCT_NUM_W-1:0]  dividend,
	input  wire logic [clg_pkg::FULL_W-1:0]     divisor,
	output logic                                done,
	output logic [clg_pkg::PCT_NUM_W-1:0]       quotient
);

	logic [clg_pkg::PCT_NUM_W-1:0] quo_q;
	logic [clg_pkg::FULL_W-1:0]    rem_q;
	logic [clg_pkg::DIV_CNT_W-1:0] cnt_q;
	logic                          busy_q;
	logic                          done_q;
	logic [clg_pkg::FULL_W:0]      shifted;
	logic [clg_pkg::FULL_W:0]      trial;
	logic                          fits;

	// restoring division, one quotient bit a cycle
	assign shifted = {rem_q, quo_q[clg_pkg::PCT_NUM_W-1]};
	assign trial   = shifted - {1'b0, divisor};
	assign fits    = !trial[clg_pkg::FULL_W];

	always_ff @(posedge clk) begin
		if (start) begin
			quo_q <= dividend;
			rem_q <= '0;
		end else if (busy_q) begin
			quo_q <= {quo_q[clg_pkg::PCT_NUM_W-2:0], fits};
			rem_q <= fits ? trial[clg_pkg::FULL_W-1:0] : shifted[clg_pkg::FULL_W-1:0];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= 1'b0;
			if (start) begin
				busy_q <= 1'b1;
				cnt_q  <= '0;
			end else if (busy_q) begin
				cnt_q <= cnt_q + clg_pkg::DIV_CNT_W'(1);
				if (cnt_q == clg_pkg::DIV_CNT_W'(clg_pkg::PCT_NUM_W - 1)) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	assign done     = done_q;
	assign quotient = quo_q;

	a_done_idle: assert property (@(posedge clk) disable iff (!arst_n)
		done_q |-> !busy_q)
		else $error("divider: done while still busy");

	a_start_idle: assert property (@(posedge clk) disable iff (!arst_n)
		start |-> !busy_q)
		else $error("divider: started while busy");

	a_done_after_run: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(done_q) |-> $past(busy_q))
		else $error("divider: done without a run");

endmodule

`default_nettype wire

>>> bench/capacitive_liquid_level_gauge_test.sv
`default_nettype none

module capacitive_liquid_level_gauge_test;

	import clg_pkg::*;

	// register index with nothing behind it, the block must drop writes to it
	localparam logic [1:0] REG_UNUSED = 2'd3;

	// cycles to let a result-less item finish before touching the registers,
	// a little over the path of a last-index sample
	localparam int SETTLE_CYCLES = 40;

	typedef enum {RX_OPEN, RX_CHOPPY, RX_BLOCKY} rx_mode_t;

	// one level reading, laid out as the block presents it
	typedef struct packed {
		logic [LEVEL_W-1:0] level_mm;
		logic [PCT_W-1:0]   level_percent;
		logic [TALLY_W-1:0] weighted_count;
	} gauge_reading_t;

	logic                 clk;
	logic                 arst_n;
	logic                 in_valid;
	wire                  in_stall;
	logic                 action;
	logic [3:0]           sensor_index;
	logic [RAW_W-1:0]     raw_count;
	logic signed [15:0]   empty_offset;
	logic [SCALE_W-1:0]   scale_factor;
	wire                  out_valid;
	logic                 out_stall;
	wire  [LEVEL_W-1:0]   level_mm;
	wire  [PCT_W-1:0]     level_percent;
	wire  [TALLY_W-1:0]   weighted_count;
	logic                 cfg_valid;
	wire                  cfg_ready;
	logic [1:0]           cfg_index;
	logic [15:0]          cfg_data;

	capacitive_liquid_level_gauge dut (
		.clk            (clk),
		.arst_n         (arst_n),
		.in_valid       (in_valid),
		.in_stall       (in_stall),
		.action         (action),
		.sensor_index   (sensor_index),
		.raw_count      (raw_count),
		.empty_offset   (empty_offset),
		.scale_factor   (scale_factor),
		.out_valid      (out_valid),
		.out_stall      (out_stall),
		.level_mm       (level_mm),
		.level_percent  (level_percent),
		.weighted_count (weighted_count),
		.cfg_valid      (cfg_valid),
		.cfg_ready      (cfg_ready),
		.cfg_index      (cfg_index),
		.cfg_data       (cfg_data)
	);

	// ---------------------------------------------------------------
	// Gauge predictor: own copy of calibration, tally and registers
	// ---------------------------------------------------------------
	logic signed [15:0]   cal_offset [SENSOR_COUNT];
	logic [SCALE_W-1:0]   cal_gain   [SENSOR_COUNT];
	int                   wet_tally;
	logic [THRESH_W-1:0]  thresh_reg;
	logic [HEIGHT_W-1:0]  height_reg;
	logic [FULL_W-1:0]    full_reg;

	// readings the block still owes us, oldest first
	gauge_reading_t pending_readings [$];

	int       errors      = 0;
	int       items_taken = 0;	// accepted items with an index in range
	int       burst_left  = 0;
	int       tx_gap_max  = 4;
	rx_mode_t rx_mode     = RX_BLOCKY;
	int       stall_left  = 0;

	// Applies one accepted item to the predictor. Returns 1 when the item
	// ends a scan, with the reading the block should then produce.
	function automatic bit advance_gauge(input clg_action_t act, input logic [3:0] idx,
			input logic [RAW_W-1:0] raw, input logic signed [15:0] off,
			input logic [SCALE_W-1:0] gain, output gauge_reading_t rd);
		longint diff, lvl, full, lim, pct;
		rd = '0;
		if (idx >= SENSOR_COUNT)
			return 0;
		if (act == ACT_CAL) begin
			cal_offset[idx] = off;
			cal_gain[idx]   = gain;
			return 0;
		end
		if (idx == 0)
			wet_tally = 0;
		// floor(diff * gain / 256) > threshold, done exactly in 64 bits
		diff = longint'(raw) - longint'(cal_offset[idx]);
		if (diff * longint'(cal_gain[idx]) >= (longint'(thresh_reg) + 1) * 256) begin
			wet_tally += (idx == 0 || idx == LAST_IDX) ? 1 : 2;
			if (wet_tally > int'(TALLY_MAX))
				wet_tally = int'(TALLY_MAX);
		end
		if (idx != LAST_IDX)
			return 0;
		lvl  = longint'(wet_tally) * longint'(height_reg >> 1);
		full = longint'(full_reg) << 8;
		lim  = full - longint'(height_reg >> 2);
		// signed compare: a tall sensor on a shallow tank clamps even when dry
		if (lvl > lim)
			lvl = full;
		if (full_reg == 0) begin
			lvl = 0;
			pct = 0;
		end else begin
			pct = lvl * 100 / longint'(full_reg);
		end
		rd.level_mm       = LEVEL_W'(lvl);
		rd.level_percent  = PCT_W'(pct);
		rd.weighted_count = TALLY_W'(wet_tally);
		return 1;
	endfunction

	// Raw count just either side of the submerged threshold for a sensor,
	// so the compare gets hit at its edge. Falls back to noise now and then
	// or where the edge cannot be reached.
	function automatic logic [RAW_W-1:0] raw_near_threshold(input int idx, input bit wet);
		longint need, r;
		if (cal_gain[idx] == 0 || $urandom_range(0, 4) == 0)
			return RAW_W'($urandom);
		need = longint'(cal_offset[idx]) + ((longint'(thresh_reg) + 1) * 256
			+ longint'(cal_gain[idx]) - 1) / longint'(cal_gain[idx]);
		r = wet ? need + longint'($urandom_range(0, 2))
			: need - 1 - longint'($urandom_range(0, 2));
		if (r < 0 || r > 65535)
			return RAW_W'($urandom);
		return r[RAW_W-1:0];
	endfunction

	// ---------------------------------------------------------------
	// Clock, receiver stall pattern, reading checker
	// ---------------------------------------------------------------
	initial begin
		clk = 1'b0;
		forever #1 clk = ~clk;
	end

	// Receiver: open, cycle-by-cycle chop, or long blocks of stall.
	always @(posedge clk) begin
		if (stall_left > 0) begin
			stall_left--;
		end else begin
			case (rx_mode)
				RX_OPEN: out_stall <= 1'b0;
				RX_CHOPPY: out_stall <= ($urandom_range(0, 9) < 4);
				default: begin
					out_stall <= ~out_stall;
					// out_stall still holds the old value here
					stall_left = out_stall ? $urandom_range(0, 8) : $urandom_range(4, 40);
				end
			endcase
		end
	end

	always @(posedge clk) begin : check_readings
		gauge_reading_t want;
		if (arst_n && out_valid && !out_stall) begin
			if (pending_readings.size() == 0) begin
				$error("unexpected reading: level_mm %0d level_percent %0d weighted_count %0d",
					level_mm, level_percent, weighted_count);
				errors++;
			end else begin
				want = pending_readings.pop_front();
				if (level_mm !== want.level_mm) begin
					$error("level_mm: expected %0d, got %0d", want.level_mm, level_mm);
					errors++;
				end
				if (level_percent !== want.level_percent) begin
					$error("level_percent: expected %0d, got %0d",
						want.level_percent, level_percent);
					errors++;
				end
				if (weighted_count !== want.weighted_count) begin
					$error("weighted_count: expected %0d, got %0d",
						want.weighted_count, weighted_count);
					errors++;
				end
			end
		end
	end

	// ---------------------------------------------------------------
	// Item and register drivers
	// ---------------------------------------------------------------

	// Sends one item. The sender runs in bursts; between bursts valid drops
	// for a random gap. Valid is only lowered when a real gap follows, so it
	// never gets two updates in one step.
	task automatic send_item(input clg_action_t act, input logic [3:0] idx,
			input logic [RAW_W-1:0] raw, input logic signed [15:0] off,
			input logic [SCALE_W-1:0] gain);
		int gap;
		gauge_reading_t rd;
		if (burst_left == 0) begin
			gap = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(0, tx_gap_max);
			if (gap != 0) begin
				in_valid <= 1'b0;
				repeat (gap) @(posedge clk);
			end
			burst_left = $urandom_range(1, 16);
		end
		action       <= act;
		sensor_index <= idx;
		raw_count    <= raw;
		empty_offset <= off;
		scale_factor <= gain;
		in_valid     <= 1'b1;
		@(posedge clk);
		while (in_stall)
			@(posedge clk);
		burst_left--;
		if (idx < SENSOR_COUNT)
			items_taken++;
		if (advance_gauge(act, idx, raw, off, gain, rd))
			pending_readings.push_back(rd);
	endtask

	// Drops valid, waits for every owed reading, then lets the core settle.
	task automatic wait_idle();
		in_valid <= 1'b0;
		burst_left = 0;
		@(posedge clk);
		while (pending_readings.size() != 0)
			@(posedge clk);
		repeat (SETTLE_CYCLES) @(posedge clk);
	endtask

	task automatic write_reg(input logic [1:0] idx, input logic [15:0] data);
		cfg_index <= idx;
		cfg_data  <= data;
		cfg_valid <= 1'b1;
		@(posedge clk);
		while (!cfg_ready)
			@(posedge clk);
		cfg_valid <= 1'b0;
		case (idx)
			REG_THRESHOLD: thresh_reg = data;
			REG_SENSOR_HEIGHT: height_reg = data;
			REG_FULL_LEVEL: full_reg = data[FULL_W-1:0];
			default: ;
		endcase
		@(posedge clk);
	endtask

	// New register set and a new idling style for the next stretch of traffic.
	task automatic set_phase(input int p, input logic [15:0] thr, input logic [15:0] hgt,
			input logic [15:0] full);
		wait_idle();
		write_reg(REG_THRESHOLD, thr);
		write_reg(REG_SENSOR_HEIGHT, hgt);
		write_reg(REG_FULL_LEVEL, full);
		case (p % 4)
			0: tx_gap_max = 0;
			1: tx_gap_max = 3;
			2: tx_gap_max = 8;
			default: tx_gap_max = 14;
		endcase
		rx_mode = rx_mode_t'(p % 3);
	endtask

	// Random traffic until quota in-range items have gone in. Mostly whole
	// scans with a random water line; the rest is recalibration, a stuck
	// electrode repeating (drives the tally into saturation) and noise.
	task automatic run_traffic(input int quota);
		int stop_at, roll, line, reps, len, mid;
		logic [3:0] idx;
		stop_at = items_taken + quota;
		while (items_taken < stop_at) begin
			roll = $urandom_range(0, 99);
			if (roll < 8) begin
				idx = ($urandom_range(0, 5) == 0) ? 4'($urandom) : 4'($urandom_range(0, LAST_IDX));
				if ($urandom_range(0, 3) == 0)
					send_item(ACT_CAL, idx, RAW_W'($urandom), 16'($urandom), SCALE_W'($urandom));
				else
					send_item(ACT_CAL, idx, RAW_W'($urandom),
						16'(int'($urandom_range(0, 4000)) - 1000),
						SCALE_W'($urandom_range(64, 1024)));
			end else if (roll < 82) begin
				line = $urandom_range(0, SENSOR_COUNT);
				for (int i = 0; i < SENSOR_COUNT; i++)
					send_item(ACT_SAMPLE, 4'(i),
						raw_near_threshold(i, (i < line) ^ ($urandom_range(0, 9) == 0)),
						16'($urandom), SCALE_W'($urandom));
			end else if (roll < 90) begin
				mid  = $urandom_range(1, LAST_IDX - 1);
				reps = $urandom_range(8, 20);
				send_item(ACT_SAMPLE, 4'd0, raw_near_threshold(0, 1'b1),
					16'($urandom), SCALE_W'($urandom));
				repeat (reps)
					send_item(ACT_SAMPLE, 4'(mid),
						raw_near_threshold(mid, $urandom_range(0, 4) != 0),
						16'($urandom), SCALE_W'($urandom));
				send_item(ACT_SAMPLE, 4'(LAST_IDX), raw_near_threshold(LAST_IDX, 1'b1),
					16'($urandom), SCALE_W'($urandom));
			end else begin
				len = $urandom_range(1, 15);
				repeat (len) begin
					idx = 4'($urandom);
					if ($urandom_range(0, 4) == 0)
						send_item(ACT_CAL, idx, RAW_W'($urandom), 16'($urandom),
							SCALE_W'($urandom));
					else
						send_item(ACT_SAMPLE, idx,
							(idx < SENSOR_COUNT && $urandom_range(0, 1) == 0)
								? raw_near_threshold(idx, $urandom_range(0, 1))
								: RAW_W'($urandom),
							16'($urandom), SCALE_W'($urandom));
				end
			end
		end
	endtask

	// ---------------------------------------------------------------
	// Tests
	// ---------------------------------------------------------------

	// One scan on the reset calibration and registers. Raw counts sit at
	// the threshold edge for each reset gain: just above it for 0x1D0, on
	// both sides for 0x100, just below for 0x1C0, plus the count extremes.
	task automatic test_reset_calibration();
		logic [RAW_W-1:0] raws [SENSOR_COUNT];
		raws = '{16'd284, 16'd513, 16'd512, 16'd0, 16'd65535, 16'd65535,
			16'd65535, 16'd65535, 16'd65535, 16'd65535, 16'd65535, 16'd293};
		for (int i = 0; i < SENSOR_COUNT; i++)
			send_item(ACT_SAMPLE, 4'(i), raws[i], 16'sd0, '0);
	endtask

	// Offset and gain extremes, out-of-range indexes on both item kinds,
	// a negative difference, a skipped and a repeated index, a zero gain.
	task automatic test_calibration_extremes();
		send_item(ACT_CAL, 4'd0, 16'd0, 16'sd32767, 15'h7FFF);
		send_item(ACT_CAL, 4'd5, 16'hFFFF, -16'sd32768, 15'h7FFF);
		send_item(ACT_CAL, 4'(LAST_IDX), 16'd0, -16'sd32768, 15'd0);
		send_item(ACT_CAL, 4'd12, 16'hFFFF, 16'sd1, 15'd1);
		send_item(ACT_SAMPLE, 4'd0, 16'd0, 16'sd0, '0);
		send_item(ACT_SAMPLE, 4'd5, 16'hFFFF, 16'sd0, '0);
		send_item(ACT_SAMPLE, 4'd15, 16'hFFFF, -16'sd1, 15'h7FFF);
		send_item(ACT_SAMPLE, 4'd3, 16'hFFFF, 16'sd0, '0);
		send_item(ACT_SAMPLE, 4'd5, 16'd0, 16'sd0, '0);
		send_item(ACT_SAMPLE, 4'(LAST_IDX), 16'hFFFF, 16'sd0, '0);
	endtask

	// Register extremes: zero and full-scale threshold, zero and largest
	// sensor height, smallest, largest and zero full height, a write to the
	// unused index.
	task automatic test_register_extremes();
		set_phase(0, 16'd0, 16'hFFFF, 16'd4095);
		run_traffic(100);
		set_phase(1, 16'hFFFF, 16'd0, 16'd1);
		run_traffic(100);
		set_phase(2, 16'($urandom_range(0, 2000)), 16'($urandom), 16'd0);
		write_reg(REG_UNUSED, 16'($urandom));
		run_traffic(100);
		set_phase(3, 16'd1000, 16'hFFFF, 16'd1);
		run_traffic(100);
	endtask

	// Random register sets; the full height is often chosen near the top
	// of the reachable level so the clamp to full gets exercised.
	task automatic test_random_traffic();
		logic [15:0] thr, hgt;
		int full;
		for (int p = 4; p < 10; p++) begin
			thr = ($urandom_range(0, 3) == 0) ? 16'($urandom) : 16'($urandom_range(0, 2000));
			hgt = 16'($urandom);
			if ($urandom_range(0, 1) == 0) begin
				full = ($urandom_range(8, 22) * int'(hgt >> 1)) >> 8;
				if (full < 1)
					full = 1;
				if (full > 4095)
					full = 4095;
			end else begin
				full = $urandom_range(1, 4095);
			end
			set_phase(p, thr, hgt, 16'(full));
			run_traffic(110);
		end
	endtask

	// ---------------------------------------------------------------
	// Sequence
	// ---------------------------------------------------------------
	initial begin
		arst_n       <= 1'b0;
		in_valid     <= 1'b0;
		action       <= ACT_CAL;
		sensor_index <= '0;
		raw_count    <= '0;
		empty_offset <= '0;
		scale_factor <= '0;
		out_stall    <= 1'b0;
		cfg_valid    <= 1'b0;
		cfg_index    <= '0;
		cfg_data     <= '0;

		// predictor starts from the reset state of the block
		for (int i = 0; i < SENSOR_COUNT; i++) begin
			cal_offset[i] = '0;
			cal_gain[i]   = SCALE_MID_RST;
		end
		cal_gain[0]        = SCALE_FIRST_RST;
		cal_gain[LAST_IDX] = SCALE_LAST_RST;
		wet_tally  = 0;
		thresh_reg = THRESH_RST;
		height_reg = HEIGHT_RST;
		full_reg   = FULL_RST;

		repeat (2) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		test_reset_calibration();
		test_calibration_extremes();
		test_register_extremes();
		test_random_traffic();

		wait_idle();
		if (errors == 0)
			$display("TEST PASSED");
		else
			$display("TEST FAILED");
		$finish;
	end

	// hard stop well past the slowest legal run
	initial begin
		#2000000;
		$display("TEST FAILED");
		$finish;
	end

endmodule

`default_nettype wire

>>> filelist.f
design/clg_pkg.sv
design/clg_cal_ram.sv
design/clg_div.sv
design/capacitive_liquid_level_gauge.sv
bench/capacitive_liquid_level_gauge_test.sv
